@@ rtl/cpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types and constants for the CRC packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // Sizes of the CRC field and of the sync words, in bytes (1..8)
    localparam int CRC_BYTES  = 4;
    localparam int SYNC_BYTES = 4;

    localparam int CRC_W     = 8 * CRC_BYTES;
    localparam int MAX_BYTES = (CRC_BYTES > SYNC_BYTES) ? CRC_BYTES : SYNC_BYTES;
    localparam int IDX_W     = $clog2(MAX_BYTES + 1);

    localparam int CFG_IDX_W = 2;
    localparam int REG_W     = 32;

    localparam logic [REG_W-1:0] DIVISOR_RESET = 32'hAC11_3912;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_DIVISOR    = 2'd0,
        CFG_START_SEQUENCE = 2'd1,
        CFG_END_SEQUENCE   = 2'd2
    } cfg_index_t;

    // Output byte kinds, carried on m_tuser
    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_CRC     = 2'd2,
        KIND_END     = 2'd3
    } byte_kind_t;

    // Sequencer phases for the item held in the input register
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_PAYLOAD,
        PH_FLUSH,
        PH_CRC,
        PH_END
    } phase_t;

endpackage

@@ rtl/crc32_packet_framer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_packet_framer_top
// Wraps payload bytes into frames: start word, payload, CRC, end word.
// ----------------------------------------------------------------------------
// Flow: a request taken on s_* is held in the input register; its result bytes
//   go out through the output register that drives m_*. Inside a frame, the
//   next payload byte is taken as the held one is loaded out, unless m_tready
//   stalls. The start word goes before a frame's first byte; after its last
//   byte, zeros flush the remainder, then the CRC and the end word go out.
// Reset: aresetn, synchronous, active low; registers back to their defaults,
//   remainder cleared, block waits for the first byte of a frame.
// ----------------------------------------------------------------------------
module crc32_packet_framer_top (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // payload in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  logic        s_tlast,   // payload_last

    // framed bytes out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic [1:0]  m_tuser,   // [1:0] byte_kind
    output logic        m_tlast    // frame_end
);

    localparam int CRC_W = cpf_pkg::CRC_W;
    localparam int IDX_W = cpf_pkg::IDX_W;

    // ---- configuration registers ----
    logic [31:0] crc_divisor_reg;
    logic [31:0] start_sequence_reg;
    logic [31:0] end_sequence_reg;

    // ---- sequencer and held request ----
    cpf_pkg::phase_t   phase_reg, phase_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              in_frame_reg, in_frame_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [7:0]        item_byte_reg;
    logic              item_last_reg;

    // ---- output register ----
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg;
    logic [1:0]        m_kind_reg;
    logic              m_last_reg;

    // ---- datapath signals ----
    logic              out_free;
    logic              emit;
    logic [7:0]        emit_byte;
    cpf_pkg::byte_kind_t emit_kind;
    logic              emit_last;
    logic              item_done;
    logic              s_accept;
    logic [63:0]       sel_word;
    logic [63:0]       div_ext;
    logic [CRC_W-1:0]  div_w;
    logic [7:0]        crc_in;

    // one CRC byte: eight MSB-first long division steps
    function automatic logic [CRC_W-1:0] crc_step8(
        input logic [CRC_W-1:0] r_in,
        input logic [7:0]       data,
        input logic [CRC_W-1:0] div
    );
        logic [CRC_W-1:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--) begin
            if (r[CRC_W-1]) begin
                r = r ^ div;
            end
            r = {r[CRC_W-2:0], data[i]};
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // divisor zero-extended or cut to the CRC width
    assign div_ext = 64'(crc_divisor_reg);
    assign div_w   = div_ext[CRC_W-1:0];

    // output register can take a byte this cycle
    assign out_free = !m_valid_reg || m_tready;

    // held request finishes when its final result byte is loaded
    assign item_done = out_free &&
                       (((phase_reg == cpf_pkg::PH_PAYLOAD) && !item_last_reg) ||
                        ((phase_reg == cpf_pkg::PH_END) && (cnt_reg == '0)));

    assign s_tready = (phase_reg == cpf_pkg::PH_IDLE) || item_done;
    assign s_accept = s_tvalid && s_tready;

    // word that the current emitting phase slices bytes out of, MSB first
    always_comb begin
        case (phase_reg)
            cpf_pkg::PH_START: sel_word = 64'(start_sequence_reg);
            cpf_pkg::PH_CRC:   sel_word = 64'(crc_reg);
            cpf_pkg::PH_END:   sel_word = 64'(end_sequence_reg);
            default:           sel_word = '0;
        endcase
    end

    // output decode
    always_comb begin
        emit      = 1'b0;
        emit_byte = sel_word[8*cnt_reg +: 8];
        emit_kind = cpf_pkg::KIND_PAYLOAD;
        emit_last = 1'b0;
        case (phase_reg)
            cpf_pkg::PH_START: begin
                emit      = out_free;
                emit_kind = cpf_pkg::KIND_START;
            end
            cpf_pkg::PH_PAYLOAD: begin
                emit      = out_free;
                emit_byte = item_byte_reg;
                emit_kind = cpf_pkg::KIND_PAYLOAD;
            end
            cpf_pkg::PH_CRC: begin
                emit      = out_free;
                emit_kind = cpf_pkg::KIND_CRC;
            end
            cpf_pkg::PH_END: begin
                emit      = out_free;
                emit_kind = cpf_pkg::KIND_END;
                emit_last = (cnt_reg == '0);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // payload byte feeds the remainder; flush cycles feed zeros
    assign crc_in = (phase_reg == cpf_pkg::PH_PAYLOAD) ? item_byte_reg : 8'h00;

    // next state
    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        case (phase_reg)
            cpf_pkg::PH_IDLE: begin
                if (s_accept) begin
                    if (in_frame_reg) begin
                        phase_next = cpf_pkg::PH_PAYLOAD;
                    end else begin
                        phase_next = cpf_pkg::PH_START;
                        cnt_next   = IDX_W'(cpf_pkg::SYNC_BYTES - 1);
                    end
                end
            end
            cpf_pkg::PH_START: begin
                if (out_free) begin
                    if (cnt_reg == '0) begin
                        phase_next = cpf_pkg::PH_PAYLOAD;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            cpf_pkg::PH_PAYLOAD: begin
                if (out_free) begin
                    crc_next      = crc_step8(crc_reg, crc_in, div_w);
                    in_frame_next = 1'b1;
                    if (item_last_reg) begin
                        phase_next = cpf_pkg::PH_FLUSH;
                        cnt_next   = IDX_W'(cpf_pkg::CRC_BYTES - 1);
                    end else if (s_accept) begin
                        phase_next = cpf_pkg::PH_PAYLOAD;
                    end else begin
                        phase_next = cpf_pkg::PH_IDLE;
                    end
                end
            end
            cpf_pkg::PH_FLUSH: begin
                crc_next = crc_step8(crc_reg, crc_in, div_w);
                if (cnt_reg == '0) begin
                    phase_next = cpf_pkg::PH_CRC;
                    cnt_next   = IDX_W'(cpf_pkg::CRC_BYTES - 1);
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            cpf_pkg::PH_CRC: begin
                if (out_free) begin
                    if (cnt_reg == '0) begin
                        phase_next = cpf_pkg::PH_END;
                        cnt_next   = IDX_W'(cpf_pkg::SYNC_BYTES - 1);
                        crc_next   = '0;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            cpf_pkg::PH_END: begin
                if (out_free) begin
                    if (cnt_reg == '0) begin
                        in_frame_next = 1'b0;
                        if (s_accept) begin
                            phase_next = cpf_pkg::PH_START;
                            cnt_next   = IDX_W'(cpf_pkg::SYNC_BYTES - 1);
                        end else begin
                            phase_next = cpf_pkg::PH_IDLE;
                        end
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
                phase_next = cpf_pkg::PH_IDLE;
            end
        endcase
    end

    assign m_valid_next = emit || (m_valid_reg && !m_tready);

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= cpf_pkg::PH_IDLE;
            cnt_reg            <= '0;
            in_frame_reg       <= 1'b0;
            crc_reg            <= '0;
            m_valid_reg        <= 1'b0;
            crc_divisor_reg    <= cpf_pkg::DIVISOR_RESET;
            start_sequence_reg <= '0;
            end_sequence_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cpf_pkg::CFG_CRC_DIVISOR:    crc_divisor_reg    <= cfg_data;
                    cpf_pkg::CFG_START_SEQUENCE: start_sequence_reg <= cfg_data;
                    cpf_pkg::CFG_END_SEQUENCE:   end_sequence_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers: held request and result byte
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_byte_reg <= s_tdata;
            item_last_reg <= s_tlast;
        end
        if (emit) begin
            m_data_reg <= emit_byte;
            m_kind_reg <= emit_kind;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/cpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
module cpf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // frame end marks only end-word bytes
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == cpf_pkg::KIND_END)
        else $error("frame end on a byte that is not end word");

    // nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // CRC bytes are followed by CRC or end-word bytes only
    a_crc_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == cpf_pkg::KIND_CRC
        |=> !(m_tvalid && (m_tuser == cpf_pkg::KIND_START ||
                           m_tuser == cpf_pkg::KIND_PAYLOAD)))
        else $error("CRC bytes interrupted");

endmodule

bind crc32_packet_framer_top cpf_checker u_cpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
